// ----- design/mbd_pkg.sv -----
// shared types and constants of the multi-button debouncer
package mbd_pkg;

    localparam int BUTTON_COUNT = 6;
    localparam int MASK_W       = 6;
    localparam int TICK_W       = 16;
    localparam int OP_W         = 3;
    localparam int IDX_W        = 3;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 8;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_CHECK   = 3'd1,
        OP_COLLECT = 3'd2,
        OP_ENABLE  = 3'd3,
        OP_DISABLE = 3'd4,
        OP_START   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        REG_PHYSICAL = 2'd0,
        REG_PRESS    = 2'd1,
        REG_RELEASE  = 2'd2,
        REG_START    = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        MODE_INACTIVE = 4'b0001,
        MODE_RELEASED = 4'b0010,
        MODE_PUSHED   = 4'b0100,
        MODE_HELD     = 4'b1000
    } t_mode;

    typedef struct packed {
        logic physical;
        logic [TICK_W-1:0] press_ticks;
        logic [TICK_W-1:0] release_ticks;
    } t_cfg;

    // per-button command decoded from one accepted request
    typedef struct packed {
        logic tick;
        logic level_high;
        logic check;
        logic collect;
        logic enable;
        logic dis;
        logic start;
        logic start_set;
    } t_btn_ctrl;

endpackage

// ----- design/mbd_button.sv -----
// mode and debounce counter of one button
module mbd_button
    import mbd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req,
    input  t_btn_ctrl i_ctrl,
    input  t_cfg      i_cfg,
    output logic      o_consumed
);

    t_mode             r_mode, n_mode;
    logic [TICK_W-1:0] r_count, n_count;
    logic              settle_hit;
    logic [TICK_W-1:0] limit;
    logic              consumed;

    always_comb begin
        n_mode   = r_mode;
        n_count  = r_count;
        consumed = 1'b0;
        limit    = (r_mode == MODE_HELD) ? i_cfg.release_ticks : i_cfg.press_ticks;
        settle_hit = !i_cfg.physical || (r_count >= limit);
        if (i_ctrl.tick) begin
            if ((r_mode == MODE_HELD && i_ctrl.level_high) ||
                (r_mode == MODE_RELEASED && !i_ctrl.level_high)) begin
                if (settle_hit) begin
                    n_mode = (r_mode == MODE_HELD) ? MODE_RELEASED : MODE_PUSHED;
                    if (i_cfg.physical) begin
                        n_count = '0;
                    end
                end else if (r_count != {TICK_W{1'b1}}) begin
                    n_count = r_count + 1'b1;
                end
            end
        end
        if ((i_ctrl.check || i_ctrl.collect) && r_mode == MODE_PUSHED) begin
            n_mode   = MODE_HELD;
            consumed = 1'b1;
        end
        if (i_ctrl.enable && r_mode == MODE_INACTIVE) begin
            n_mode = MODE_RELEASED;
        end
        if (i_ctrl.dis) begin
            n_mode = MODE_INACTIVE;
        end
        if (i_ctrl.start) begin
            n_count = '0;
            n_mode  = i_ctrl.start_set ? MODE_RELEASED : MODE_INACTIVE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_INACTIVE;
            r_count <= '0;
        end else if (i_req) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    assign o_consumed = i_req && consumed;

endmodule

// ----- design/multi_button_debouncer.sv -----
// top level of the multi-button debouncer
// Debounces six active-low buttons. Requests arrive on the slave stream
// (i_s_tvalid/o_s_tready/i_s_tdata) as op, pin levels and button index;
// each request gives exactly one result on the master stream holding the
// mask of pushed buttons that the request consumed (zero for tick, enable,
// disable, start and unused ops).
// The result is registered in the output register as the request is
// taken. Throughput is one request per cycle unless a stalled receiver holds
// the output register, set by the per-button update logic, which works on all
// buttons in parallel in the cycle of acceptance.
// A stalled receiver holds the result in the output register; the next
// request is taken in the same cycle the waiting result is taken, so a
// full output register blocks the slave side only while o_m_tvalid is
// high and i_m_tready is low.
// Reset makes every button inactive with zero count, clears the started
// flag (ticks are ignored until a start op) and loads the register
// defaults: physical mode, press and release thresholds 10, start mask 63.
// Registers sit on the APB port at byte addresses 0, 4, 8 and 12 and are to be
// written by the user only while the block is idle; the block does not enforce it.
module multi_button_debouncer
    import mbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // op[2:0], pin_levels[8:3], button_index[11:9]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // pushed_mask[5:0]
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    logic              r_physical;
    logic [TICK_W-1:0] r_press_ticks;
    logic [TICK_W-1:0] r_release_ticks;
    logic [MASK_W-1:0] r_start_mask;
    logic              r_started;
    logic              r_out_valid;
    logic [MASK_W-1:0] r_out_mask, n_out_mask;

    t_cfg              cfg;
    t_reg_idx          reg_idx;
    logic              cfg_write;
    logic              req;
    t_op               op;
    logic [MASK_W-1:0] levels;
    logic [IDX_W-1:0]  idx;
    logic [BUTTON_COUNT-1:0] consumed;

    // configuration port
    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_physical      <= 1'b1;
            r_press_ticks   <= TICK_W'(10);
            r_release_ticks <= TICK_W'(10);
            r_start_mask    <= {MASK_W{1'b1}};
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_PHYSICAL: r_physical      <= pwdata[0];
                REG_PRESS:    r_press_ticks   <= pwdata[TICK_W-1:0];
                REG_RELEASE:  r_release_ticks <= pwdata[TICK_W-1:0];
                REG_START:    r_start_mask    <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PHYSICAL: prdata = PDATA_W'(r_physical);
            REG_PRESS:    prdata = PDATA_W'(r_press_ticks);
            REG_RELEASE:  prdata = PDATA_W'(r_release_ticks);
            REG_START:    prdata = PDATA_W'(r_start_mask);
            default:      prdata = '0;
        endcase
    end

    assign cfg.physical      = r_physical;
    assign cfg.press_ticks   = r_press_ticks;
    assign cfg.release_ticks = r_release_ticks;

    // request decode
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign req        = i_s_tvalid && o_s_tready;
    assign op         = t_op'(i_s_tdata[OP_W-1:0]);
    assign levels     = i_s_tdata[OP_W+MASK_W-1:OP_W];
    assign idx        = i_s_tdata[OP_W+MASK_W+IDX_W-1:OP_W+MASK_W];

    for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_btn
        t_btn_ctrl ctrl;
        logic      hit;

        assign hit = (32'(idx) == i);

        always_comb begin
            ctrl.tick       = (op == OP_TICK) && r_started;
            ctrl.check      = (op == OP_CHECK) && hit;
            ctrl.collect    = (op == OP_COLLECT);
            ctrl.enable     = (op == OP_ENABLE) && hit;
            ctrl.dis        = (op == OP_DISABLE) && hit;
            ctrl.start      = (op == OP_START);
            ctrl.level_high = 1'b1;
            ctrl.start_set  = 1'b0;
            if (i < MASK_W) begin
                ctrl.level_high = levels[i % MASK_W];
                // the last masked button only starts in virtual mode
                ctrl.start_set  = r_start_mask[i % MASK_W] &&
                                  ((i != MASK_W - 1) || !r_physical);
            end
        end

        mbd_button u_button (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_req     (req),
            .i_ctrl    (ctrl),
            .i_cfg     (cfg),
            .o_consumed(consumed[i])
        );
    end

    // buttons above the mask width report nothing
    always_comb begin
        n_out_mask = '0;
        for (int i = 0; i < BUTTON_COUNT && i < MASK_W; i++) begin
            n_out_mask[i] = consumed[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (req && op == OP_START) begin
                r_started <= 1'b1;
            end
            if (req) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req) begin
            r_out_mask <= n_out_mask;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'(r_out_mask);

`ifndef NO_ASSERTIONS
    a_start_sets_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req && op == OP_START |=> r_started)
        else $error("started flag not set after start");

    a_quiet_ops_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req && op != OP_CHECK && op != OP_COLLECT |=> o_m_tdata == '0)
        else $error("non-reading op reported pushed buttons");

    a_check_one_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req && op == OP_CHECK |=> $countones(o_m_tdata) <= 1)
        else $error("check reported more than one button");

    a_result_follows_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req |=> o_m_tvalid)
        else $error("accepted request gave no result");
`endif

endmodule

// ----- verif/mbd_checker.sv -----
// request/result checker for the multi-button debouncer
module mbd_checker
    import mbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // op[2:0], pin_levels[8:3], button_index[11:9]
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,   // pushed_mask[5:0]
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    input  logic                 pready,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_request_count,
    output int                   o_pushed_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 40;

    // register copies
    logic              cfg_physical;
    logic [TICK_W-1:0] cfg_press;
    logic [TICK_W-1:0] cfg_release;
    logic [MASK_W-1:0] cfg_start_mask;

    // button state
    t_mode             btn_mode [BUTTON_COUNT];
    logic [TICK_W-1:0] tick_cnt [BUTTON_COUNT];
    logic              started;

    logic [MASK_W-1:0] pushed_mask_q [$];

    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic reset_state();
        int b;
        cfg_physical   = 1'b1;
        cfg_press      = 16'd10;
        cfg_release    = 16'd10;
        cfg_start_mask = '1;
        for (b = 0; b < BUTTON_COUNT; b++) begin
            btn_mode[b] = MODE_INACTIVE;
            tick_cnt[b] = '0;
        end
        started = 1'b0;
        pushed_mask_q.delete();
    endtask

    // counts one level tick; true once the level has been seen long enough, or at once in virtual mode
    function automatic bit debounce_done(input int b, input logic [TICK_W-1:0] limit);
        if (!cfg_physical)
            return 1'b1;
        if (tick_cnt[b] >= limit) begin
            tick_cnt[b] = '0;
            return 1'b1;
        end
        if (tick_cnt[b] != '1)
            tick_cnt[b] = tick_cnt[b] + 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [MASK_W-1:0] apply_request(input logic [S_TDATA_W-1:0] req);
        logic [OP_W-1:0]   op;
        logic [MASK_W-1:0] lv;
        logic [IDX_W-1:0]  idx;
        logic [MASK_W-1:0] mask;
        bit                in_range;
        int                b;
        op       = req[OP_W-1:0];
        lv       = req[OP_W+MASK_W-1:OP_W];
        idx      = req[OP_W+MASK_W+IDX_W-1:OP_W+MASK_W];
        mask     = '0;
        in_range = idx < BUTTON_COUNT;
        case (op)
            OP_TICK: begin
                if (started) begin
                    for (b = 0; b < BUTTON_COUNT; b++) begin
                        if (btn_mode[b] == MODE_HELD && lv[b]) begin
                            if (debounce_done(b, cfg_release))
                                btn_mode[b] = MODE_RELEASED;
                        end else if (btn_mode[b] == MODE_RELEASED && !lv[b]) begin
                            if (debounce_done(b, cfg_press))
                                btn_mode[b] = MODE_PUSHED;
                        end
                    end
                end
            end
            OP_CHECK: begin
                if (in_range && btn_mode[idx] == MODE_PUSHED) begin
                    btn_mode[idx] = MODE_HELD;
                    mask[idx]     = 1'b1;
                end
            end
            OP_COLLECT: begin
                for (b = 0; b < BUTTON_COUNT; b++) begin
                    if (btn_mode[b] == MODE_PUSHED) begin
                        btn_mode[b] = MODE_HELD;
                        mask[b]     = 1'b1;
                    end
                end
            end
            OP_ENABLE: begin
                if (in_range && btn_mode[idx] == MODE_INACTIVE)
                    btn_mode[idx] = MODE_RELEASED;
            end
            OP_DISABLE: begin
                if (in_range)
                    btn_mode[idx] = MODE_INACTIVE;
            end
            OP_START: begin
                for (b = 0; b < BUTTON_COUNT; b++) begin
                    btn_mode[b] = MODE_INACTIVE;
                    tick_cnt[b] = '0;
                    // top button only comes up in virtual mode
                    if (cfg_start_mask[b] && (b != BUTTON_COUNT - 1 || !cfg_physical))
                        btn_mode[b] = MODE_RELEASED;
                end
                started = 1'b1;
            end
            default: ;
        endcase
        return mask;
    endfunction

    always @(posedge i_clk) begin
        logic [MASK_W-1:0] want;
        if (!i_rst_n) begin
            reset_state();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_PHYSICAL: cfg_physical   = pwdata[0];
                    REG_PRESS:    cfg_press      = pwdata[TICK_W-1:0];
                    REG_RELEASE:  cfg_release    = pwdata[TICK_W-1:0];
                    REG_START:    cfg_start_mask = pwdata[MASK_W-1:0];
                    default: ;
                endcase
            end
            // the result taken at this edge belongs to an earlier request
            if (i_m_tvalid && i_m_tready) begin
                if (pushed_mask_q.size() == 0) begin
                    report_mismatch($sformatf("result %h with no request pending", i_m_tdata));
                end else begin
                    want = pushed_mask_q.pop_front();
                    if (i_m_tdata[MASK_W-1:0] !== want)
                        report_mismatch($sformatf("pushed_mask %b, expected %b",
                                                  i_m_tdata[MASK_W-1:0], want));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                want = apply_request(i_s_tdata);
                pushed_mask_q.push_back(want);
                o_request_count <= o_request_count + 1;
                o_pushed_count  <= o_pushed_count + $countones(want);
            end
        end
        o_pending <= pushed_mask_q.size();
    end

endmodule

// ----- verif/multi_button_debouncer_tb.sv -----
// testbench top of the multi-button debouncer: stimulus and verdict
module multi_button_debouncer_tb;
    import mbd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              CLK_PERIOD     = 8;
    localparam int              RESET_CYCLES   = 9;
    localparam int              WATCHDOG_LIMIT = 2000;
    localparam int              RX_HOLD_CYCLES = 90;
    localparam logic [OP_W-1:0] OP_SPARE_LO    = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI    = 3'd7;
    localparam logic [MASK_W-1:0] ALL_HIGH     = '1;
    localparam logic [MASK_W-1:0] ALL_LOW      = '0;

    typedef enum {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} t_idle;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [PADDR_W-1:0]   paddr      = '0;
    logic [PDATA_W-1:0]   pwdata     = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int fail_count;
    int pending;
    int request_count;
    int pushed_count;

    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int rx_hold_req  = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;
    int quiet_cycles = 0;

    logic [MASK_W-1:0] pin_state = '1;

    multi_button_debouncer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    mbd_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .i_s_tready      (o_s_tready),
        .i_s_tdata       (i_s_tdata),
        .i_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .i_m_tdata       (o_m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_request_count (request_count),
        .o_pushed_count  (pushed_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // receiver: random stalls, plus a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (rx_hold_seen != rx_hold_req) begin
            rx_hold_seen = rx_hold_req;
            rx_hold_left = RX_HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [MASK_W-1:0] lv,
                                input logic [IDX_W-1:0] idx);
        if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_gap_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_TDATA_W - OP_W - MASK_W - IDX_W){1'b0}}, idx, lv, op};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // registers only change once every result is back and the pipe is quiet
    task automatic load_config(input logic phys, input logic [TICK_W-1:0] press,
                               input logic [TICK_W-1:0] rel, input logic [MASK_W-1:0] mask);
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
        apb_write(REG_PHYSICAL, PDATA_W'(phys));
        apb_write(REG_PRESS, PDATA_W'(press));
        apb_write(REG_RELEASE, PDATA_W'(rel));
        apb_write(REG_START, PDATA_W'(mask));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_idle(input t_idle mode);
        case (mode)
            IDLE_NONE: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
            IDLE_TX:   begin tx_gap_pct = 53; rx_stall_pct = 0;  end
            IDLE_RX:   begin tx_gap_pct = 0;  rx_stall_pct = 53; end
            default:   begin tx_gap_pct = 36; rx_stall_pct = 36; end
        endcase
    endtask

    // mostly ticks over slowly drifting levels so debounce counts can mature
    task automatic run_random(input int n_items);
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        int               k;
        int               r;
        send_request(OP_START, pin_state, '0);
        for (k = 0; k < n_items; k++) begin
            r   = $urandom_range(99);
            idx = ($urandom_range(99) < 88) ? IDX_W'($urandom_range(BUTTON_COUNT - 1))
                                            : IDX_W'($urandom_range(7, BUTTON_COUNT));
            if (r < 58)      op = OP_TICK;
            else if (r < 70) op = OP_CHECK;
            else if (r < 80) op = OP_COLLECT;
            else if (r < 88) op = OP_ENABLE;
            else if (r < 94) op = OP_DISABLE;
            else if (r < 96) op = OP_START;
            else if (r < 98) op = OP_SPARE_LO;
            else             op = OP_SPARE_HI;
            if (op == OP_TICK) begin
                r = $urandom_range(99);
                if (r < 5)
                    pin_state = MASK_W'($urandom);
                else if (r < 25)
                    pin_state[$urandom_range(BUTTON_COUNT - 1)] ^= 1'b1;
            end
            send_request(op, (op == OP_TICK) ? pin_state : MASK_W'($urandom), idx);
        end
    endtask

    task automatic run_phase(input logic phys, input logic [TICK_W-1:0] press,
                             input logic [TICK_W-1:0] rel, input logic [MASK_W-1:0] mask,
                             input t_idle mode, input int n_items);
        load_config(phys, press, rel, mask);
        set_idle(mode);
        run_random(n_items);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: short thresholds so presses and releases show up quickly
        load_config(1'b1, 16'd2, 16'd1, ALL_HIGH);
        send_request(OP_TICK, ALL_LOW, 3'd0);          // ignored before start
        send_request(OP_ENABLE, ALL_HIGH, 3'd0);       // acts before start
        send_request(OP_CHECK, ALL_LOW, 3'd7);
        send_request(OP_ENABLE, ALL_LOW, 3'd6);
        send_request(OP_DISABLE, ALL_LOW, 3'd7);
        send_request(OP_SPARE_LO, ALL_HIGH, 3'd7);
        send_request(OP_SPARE_HI, ALL_LOW, 3'd0);
        send_request(OP_START, ALL_HIGH, 3'd0);        // top button stays inactive
        repeat (3) send_request(OP_TICK, ALL_LOW, 3'd0);
        send_request(OP_TICK, ALL_HIGH, 3'd0);         // bounce on pushed buttons
        send_request(OP_CHECK, ALL_LOW, 3'd2);
        send_request(OP_CHECK, ALL_LOW, 3'd2);
        send_request(OP_COLLECT, ALL_LOW, 3'd0);
        send_request(OP_COLLECT, ALL_LOW, 3'd0);
        repeat (2) send_request(OP_TICK, ALL_HIGH, 3'd0);
        send_request(OP_DISABLE, ALL_LOW, 3'd0);
        send_request(OP_ENABLE, ALL_LOW, 3'd0);
        send_request(OP_ENABLE, ALL_LOW, 3'd5);
        repeat (3) send_request(OP_TICK, ALL_LOW, 3'd0);
        send_request(OP_COLLECT, ALL_HIGH, 3'd0);

        run_phase(1'b1, 16'd0,     16'd0,     ALL_HIGH, IDLE_NONE, 250);
        run_phase(1'b1, 16'd3,     16'd2,     6'h2A,    IDLE_TX,   250);
        run_phase(1'b0, 16'd5,     16'd5,     ALL_HIGH, IDLE_RX,   250);
        run_phase(1'b1, 16'd10,    16'd10,    ALL_HIGH, IDLE_BOTH, 400);
        run_phase(1'b0, 16'd0,     16'hFFFF,  ALL_LOW,  IDLE_NONE, 200);
        run_phase(1'b1, 16'd1,     16'd4,     6'h1F,    IDLE_BOTH, 300);
        run_phase(1'b1, 16'hFFFF,  16'hFFFF,  ALL_HIGH, IDLE_TX,   100);

        // back-pressure: receiver holds off while requests keep coming
        load_config(1'b0, 16'd0, 16'd0, ALL_HIGH);
        set_idle(IDLE_NONE);
        rx_hold_req = rx_hold_req + 1;
        run_random(150);

        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);

        $display("run covered %0d requests with %0d button pushes consumed", request_count,
                 pushed_count);
        $display("across nine register settings, four idle patterns and one long stall");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
